>>> src/mjsr_pkg.sv
package mjsr_pkg;

	localparam int JOINTS = 16;
	localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	localparam int IDX_W = 4;
	localparam int ANG_W = 32;
	localparam int DT_W = 16;
	localparam int SPD_W = 23;
	localparam int DZW_W = 21;
	localparam int FRAC = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 23;

	localparam logic [SPD_W-1:0] MAX_SPEED_RST = 23'd80067;
	localparam logic [SPD_W-1:0] MAX_ACCEL_RST = 23'd148697;
	localparam logic DZ_ON_RST = 1'b1;
	localparam logic [DZW_W-1:0] DZ_WIDTH_RST = 21'd5719;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_SPEED = 2'd0,
		CFG_MAX_ACCEL = 2'd1,
		CFG_DZ_ON = 2'd2,
		CFG_DZ_WIDTH = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TGT,
		ST_ACC,
		ST_SCAN,
		ST_SPD,
		ST_STEP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic latch_in;
		logic tgt_write;
		logic acc_calc;
		logic clr_idx;
		logic adv_idx;
		logic spd_calc;
		logic step_calc;
		logic upd;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic cur_moving;
		logic idx_last;
		logic out_busy;
	} sts_t;

endpackage

>>> src/mjsr_if.sv
interface mjsr_in_if;
	logic valid;
	logic ready;
	logic func;
	logic [mjsr_pkg::IDX_W-1:0] joint_index;
	logic signed [mjsr_pkg::ANG_W-1:0] target_angle;
	logic [mjsr_pkg::DT_W-1:0] elapsed;

	modport source (output valid, func, joint_index, target_angle, elapsed, input ready);
	modport sink (input valid, func, joint_index, target_angle, elapsed, output ready);
endinterface

interface mjsr_out_if;
	logic valid;
	logic ready;
	logic [mjsr_pkg::IDX_W-1:0] joint_out;
	logic signed [mjsr_pkg::ANG_W-1:0] position;
	logic last;

	modport source (output valid, joint_out, position, last, input ready);
	modport sink (input valid, joint_out, position, last, output ready);
endinterface

>>> src/mjsr_ctrl.sv
module mjsr_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  mjsr_pkg::sts_t sts,
	output mjsr_pkg::cmd_t cmd
);

	mjsr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mjsr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mjsr_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.is_tick ? mjsr_pkg::ST_ACC : mjsr_pkg::ST_TGT;
				end
			end
			mjsr_pkg::ST_TGT: state_d = mjsr_pkg::ST_IDLE;
			mjsr_pkg::ST_ACC: state_d = mjsr_pkg::ST_SCAN;
			mjsr_pkg::ST_SCAN: begin
				if (sts.cur_moving) begin
					state_d = mjsr_pkg::ST_SPD;
				end else if (sts.idx_last) begin
					state_d = mjsr_pkg::ST_IDLE;
				end
			end
			mjsr_pkg::ST_SPD: state_d = mjsr_pkg::ST_STEP;
			mjsr_pkg::ST_STEP: state_d = mjsr_pkg::ST_UPD;
			mjsr_pkg::ST_UPD: begin
				if (!sts.out_busy) begin
					state_d = sts.idx_last ? mjsr_pkg::ST_IDLE : mjsr_pkg::ST_SCAN;
				end
			end
			default: state_d = mjsr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			mjsr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.latch_in = in_valid;
			end
			mjsr_pkg::ST_TGT: cmd.tgt_write = 1'b1;
			mjsr_pkg::ST_ACC: begin
				cmd.acc_calc = 1'b1;
				cmd.clr_idx = 1'b1;
			end
			mjsr_pkg::ST_SCAN: cmd.adv_idx = !sts.cur_moving && !sts.idx_last;
			mjsr_pkg::ST_SPD: cmd.spd_calc = 1'b1;
			mjsr_pkg::ST_STEP: cmd.step_calc = 1'b1;
			mjsr_pkg::ST_UPD: begin
				cmd.upd = !sts.out_busy;
				cmd.adv_idx = !sts.out_busy && !sts.idx_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

>>> src/mjsr_dp.sv
module mjsr_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [mjsr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [mjsr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_func,
	input  logic [mjsr_pkg::IDX_W-1:0] in_joint_index,
	input  logic signed [mjsr_pkg::ANG_W-1:0] in_target_angle,
	input  logic [mjsr_pkg::DT_W-1:0] in_elapsed,
	input  logic out_ready,
	output logic out_valid,
	output logic [mjsr_pkg::IDX_W-1:0] out_joint,
	output logic signed [mjsr_pkg::ANG_W-1:0] out_position,
	output logic out_last,
	input  mjsr_pkg::cmd_t cmd,
	output mjsr_pkg::sts_t sts
);

	localparam int JW = mjsr_pkg::JW;
	localparam int AW = mjsr_pkg::ANG_W;
	localparam int SW = mjsr_pkg::SPD_W;
	localparam int DW = mjsr_pkg::DT_W;

	function automatic logic [SW-1:0] step_sel(input logic [SW+DW-1:0] p);
		return p[mjsr_pkg::FRAC +: SW];
	endfunction

	logic [SW-1:0] max_speed_q, max_accel_q;
	logic dz_on_q;
	logic [mjsr_pkg::DZW_W-1:0] dz_width_q;

	logic signed [AW-1:0] cur_q [mjsr_pkg::JOINTS];
	logic signed [AW-1:0] goal_q [mjsr_pkg::JOINTS];
	logic [SW-1:0] spd_arr_q [mjsr_pkg::JOINTS];
	logic [mjsr_pkg::JOINTS-1:0] reg_q, mov_q;

	logic tgt_valid_q;
	logic [JW-1:0] tgt_idx_q;
	logic signed [AW-1:0] tgt_ang_q;
	logic [DW-1:0] dt_q;

	logic [JW-1:0] idx_q;
	logic [SW-1:0] acc_q, spd_q, step_q;
	logic [AW:0] dist_q;

	logic out_valid_q, out_last_q;
	logic [mjsr_pkg::IDX_W-1:0] out_joint_q;
	logic signed [AW-1:0] out_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= mjsr_pkg::MAX_SPEED_RST;
			max_accel_q <= mjsr_pkg::MAX_ACCEL_RST;
			dz_on_q <= mjsr_pkg::DZ_ON_RST;
			dz_width_q <= mjsr_pkg::DZ_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (mjsr_pkg::cfg_reg_t'(cfg_idx))
				mjsr_pkg::CFG_MAX_SPEED: max_speed_q <= cfg_data[SW-1:0];
				mjsr_pkg::CFG_MAX_ACCEL: max_accel_q <= cfg_data[SW-1:0];
				mjsr_pkg::CFG_DZ_ON: dz_on_q <= cfg_data[0];
				mjsr_pkg::CFG_DZ_WIDTH: dz_width_q <= cfg_data[mjsr_pkg::DZW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			tgt_valid_q <= 32'(in_joint_index) < mjsr_pkg::JOINTS;
			tgt_idx_q <= JW'(in_joint_index);
			tgt_ang_q <= in_target_angle;
			dt_q <= in_elapsed;
		end
	end

	// target item
	logic t_reg;
	logic signed [AW-1:0] t_cur, t_goal, t_goal_new;
	logic [SW-1:0] t_spd, t_spd_new;
	logic signed [AW:0] t_diff;
	logic [AW:0] t_abs;
	logic t_take;

	always_comb begin
		t_reg = reg_q[tgt_idx_q];
		t_cur = t_reg ? cur_q[tgt_idx_q] : '0;
		t_goal = t_reg ? goal_q[tgt_idx_q] : '0;
		t_spd = t_reg ? spd_arr_q[tgt_idx_q] : '0;
		t_diff = {tgt_ang_q[AW-1], tgt_ang_q} - {t_cur[AW-1], t_cur};
		t_abs = t_diff[AW] ? (AW+1)'(-t_diff) : (AW+1)'(t_diff);
		t_take = !dz_on_q || (t_abs >= (AW+1)'(dz_width_q));
		t_goal_new = t_take ? tgt_ang_q : t_goal;
		t_spd_new = t_take ? '0 : t_spd;
	end

	// tick walk
	logic signed [AW-1:0] w_cur, w_goal, w_new;
	logic [SW-1:0] w_spd;
	logic [SW:0] w_sum;
	logic [SW+DW-1:0] acc_prod, step_prod;
	logic signed [AW:0] w_diff;
	logic w_above;

	always_comb begin
		w_cur = cur_q[idx_q];
		w_goal = goal_q[idx_q];
		w_spd = spd_arr_q[idx_q];
		acc_prod = (SW+DW)'(max_accel_q) * (SW+DW)'(dt_q);
		w_sum = {1'b0, w_spd} + {1'b0, acc_q};
		step_prod = (SW+DW)'(spd_q) * (SW+DW)'(dt_q);
		w_diff = {w_goal[AW-1], w_goal} - {w_cur[AW-1], w_cur};
		if (dist_q <= (AW+1)'(step_q)) begin
			w_new = w_goal;
		end else if (w_goal > w_cur) begin
			w_new = w_cur + AW'(step_q);
		end else begin
			w_new = w_cur - AW'(step_q);
		end
		w_above = 1'b0;
		for (int j = 0; j < mjsr_pkg::JOINTS; j++) begin
			if (mov_q[j] && (j > int'(idx_q))) begin
				w_above = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_calc) begin
			acc_q <= step_sel(acc_prod);
		end
		if (cmd.spd_calc) begin
			spd_q <= (w_sum > {1'b0, max_speed_q}) ? max_speed_q : w_sum[SW-1:0];
		end
		if (cmd.step_calc) begin
			step_q <= step_sel(step_prod);
			dist_q <= w_diff[AW] ? (AW+1)'(-w_diff) : (AW+1)'(w_diff);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tgt_write && tgt_valid_q) begin
			cur_q[tgt_idx_q] <= t_cur;
			goal_q[tgt_idx_q] <= t_goal_new;
			spd_arr_q[tgt_idx_q] <= t_spd_new;
		end else if (cmd.upd) begin
			cur_q[idx_q] <= w_new;
			spd_arr_q[idx_q] <= spd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_q <= '0;
			mov_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.tgt_write && tgt_valid_q) begin
				reg_q[tgt_idx_q] <= 1'b1;
				mov_q[tgt_idx_q] <= t_goal_new != t_cur;
			end else if (cmd.upd) begin
				mov_q[idx_q] <= w_new != w_goal;
			end
			if (cmd.clr_idx) begin
				idx_q <= '0;
			end else if (cmd.adv_idx) begin
				idx_q <= idx_q + JW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.upd) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			out_joint_q <= mjsr_pkg::IDX_W'(idx_q);
			out_pos_q <= w_new;
			out_last_q <= !w_above;
		end
	end

	assign out_valid = out_valid_q;
	assign out_joint = out_joint_q;
	assign out_position = out_pos_q;
	assign out_last = out_last_q;

	assign sts.is_tick = in_func;
	assign sts.cur_moving = mov_q[idx_q];
	assign sts.idx_last = idx_q == JW'(mjsr_pkg::JOINTS - 1);
	assign sts.out_busy = out_valid_q && !out_ready;

endmodule

>>> src/multi_joint_setpoint_ramp.sv
// Setpoint ramp for a table of 16 joints in Q16.16 radians. A target word
// (func 0) registers its joint on first use and sets a new goal unless the
// dead zone rejects it; it gives no result. A tick word (func 1) walks the
// joint table in index order, one joint per cycle while it passes joints
// at their goal; on each joint that is off its goal it adds and clamps the
// speed, multiplies out the step and updates the position, in that order,
// and the sink can hold the walk by stalling the output register. One
// result word per moved joint; last marks the final one.
// Write configuration only while the block is idle.
module multi_joint_setpoint_ramp (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [mjsr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [mjsr_pkg::CFG_DATA_W-1:0] cfg_data,
	mjsr_in_if.sink in_ch,
	mjsr_out_if.source out_ch
);

	mjsr_pkg::cmd_t cmd;
	mjsr_pkg::sts_t sts;
	logic in_ready;

	assign in_ch.ready = in_ready;

	mjsr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	mjsr_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_func(in_ch.func),
		.in_joint_index(in_ch.joint_index),
		.in_target_angle(in_ch.target_angle),
		.in_elapsed(in_ch.elapsed),
		.out_ready(out_ch.ready),
		.out_valid(out_ch.valid),
		.out_joint(out_ch.joint_out),
		.out_position(out_ch.position),
		.out_last(out_ch.last),
		.cmd(cmd),
		.sts(sts)
	);

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam logic FUNC_TARGET = 1'b0;
	localparam logic FUNC_TICK = 1'b1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_WORDS = 23;

	typedef struct packed {
		logic [mjsr_pkg::IDX_W-1:0] joint;
		logic signed [mjsr_pkg::ANG_W-1:0] position;
		logic last;
	} move_word_t;

	localparam move_word_t NO_MOVE = '0;

	typedef struct {
		logic func;
		logic [mjsr_pkg::IDX_W-1:0] joint;
		logic signed [mjsr_pkg::ANG_W-1:0] angle;
		logic [mjsr_pkg::DT_W-1:0] dt;
		logic typed;
		logic typed_one;
		move_word_t typed_move;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	mjsr_pkg::cfg_reg_t cfg_idx;
	logic [mjsr_pkg::CFG_DATA_W-1:0] cfg_data;

	mjsr_in_if in_ch();
	mjsr_out_if out_ch();

	multi_joint_setpoint_ramp dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic signed [mjsr_pkg::ANG_W-1:0] ramp_pos [mjsr_pkg::JOINTS];
	logic signed [mjsr_pkg::ANG_W-1:0] ramp_goal [mjsr_pkg::JOINTS];
	logic [31:0] ramp_speed [mjsr_pkg::JOINTS];
	logic ramp_known [mjsr_pkg::JOINTS];
	logic [mjsr_pkg::SPD_W-1:0] lim_speed = mjsr_pkg::MAX_SPEED_RST;
	logic [mjsr_pkg::SPD_W-1:0] lim_accel = mjsr_pkg::MAX_ACCEL_RST;
	logic dz_on = mjsr_pkg::DZ_ON_RST;
	logic [mjsr_pkg::DZW_W-1:0] dz_width = mjsr_pkg::DZ_WIDTH_RST;

	move_word_t tick_moves [$];
	move_word_t expected_moves [$];
	int misses = 0;
	int cycles = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;

	stim_row_t directed_rows [19] = '{
		'{FUNC_TICK, 4'd0, 32'sd0, 16'd65535, 1'b1, 1'b0, NO_MOVE},
		'{FUNC_TARGET, 4'd0, 32'sd65536, 16'd0, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TARGET, 4'd1, 32'sd5718, 16'd0, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TICK, 4'd0, 32'sd0, 16'd0, 1'b1, 1'b1, '{4'd0, 32'sd0, 1'b1}},
		'{FUNC_TARGET, 4'd2, -32'sd5719, 16'd0, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TICK, 4'd0, 32'sd0, 16'd65535, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TARGET, 4'd15, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TARGET, 4'd3, 32'sh8000_0000, 16'd0, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TICK, 4'd15, 32'sh7FFF_FFFF, 16'd1, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TICK, 4'd0, 32'sd0, 16'd32768, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TARGET, 4'd1, -32'sd5719, 16'd0, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TARGET, 4'd0, 32'sd65636, 16'd0, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TICK, 4'd0, 32'sd0, 16'd65535, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TARGET, 4'd5, 32'sd0, 16'd0, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TICK, 4'd0, 32'sd0, 16'd0, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TICK, 4'd0, 32'sd0, 16'd65535, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TICK, 4'd0, 32'sd0, 16'd65535, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TARGET, 4'd2, -32'sd5719, 16'd0, 1'b0, 1'b0, NO_MOVE},
		'{FUNC_TICK, 4'd0, 32'sd0, 16'd40000, 1'b0, 1'b0, NO_MOVE}
	};

	function automatic longint gap_of(logic signed [mjsr_pkg::ANG_W-1:0] a,
			logic signed [mjsr_pkg::ANG_W-1:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		return (d < 0) ? -d : d;
	endfunction

	task automatic step_ramp(input logic func, input logic [mjsr_pkg::IDX_W-1:0] j,
			input logic signed [mjsr_pkg::ANG_W-1:0] ang,
			input logic [mjsr_pkg::DT_W-1:0] dt);
		move_word_t w;
		longint gap;
		longint spd;
		longint stp;
		tick_moves.delete();
		if (func == FUNC_TARGET) begin
			if (!ramp_known[j]) begin
				ramp_known[j] = 1'b1;
				ramp_pos[j] = '0;
				ramp_goal[j] = '0;
				ramp_speed[j] = '0;
			end
			if (!dz_on || gap_of(ang, ramp_pos[j]) >= longint'(dz_width)) begin
				ramp_goal[j] = ang;
				ramp_speed[j] = '0;
			end
		end else begin
			for (int i = 0; i < mjsr_pkg::JOINTS; i++) begin
				if (ramp_known[i] && ramp_pos[i] != ramp_goal[i]) begin
					gap = gap_of(ramp_goal[i], ramp_pos[i]);
					spd = longint'(ramp_speed[i])
						+ ((longint'(lim_accel) * longint'(dt)) >>> mjsr_pkg::FRAC);
					if (spd > longint'(lim_speed))
						spd = longint'(lim_speed);
					ramp_speed[i] = 32'(spd);
					stp = (spd * longint'(dt)) >>> mjsr_pkg::FRAC;
					if (gap <= stp)
						ramp_pos[i] = ramp_goal[i];
					else if (ramp_goal[i] > ramp_pos[i])
						ramp_pos[i] = 32'(longint'(ramp_pos[i]) + stp);
					else
						ramp_pos[i] = 32'(longint'(ramp_pos[i]) - stp);
					w.joint = i[mjsr_pkg::IDX_W-1:0];
					w.position = ramp_pos[i];
					w.last = 1'b0;
					tick_moves = {tick_moves, w};
				end
			end
			if (tick_moves.size() > 0)
				tick_moves[tick_moves.size()-1].last = 1'b1;
		end
	endtask

	task automatic send_word(input stim_row_t r);
		if (tx_idle_pct > 0) begin
			while ($urandom_range(0, 99) < tx_idle_pct) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= r.func;
		in_ch.joint_index <= r.joint;
		in_ch.target_angle <= r.angle;
		in_ch.elapsed <= r.dt;
		do
			@(posedge clk);
		while (!in_ch.ready);
		step_ramp(r.func, r.joint, r.angle, r.dt);
		if (r.typed) begin
			if (r.typed_one)
				expected_moves = {expected_moves, r.typed_move};
		end else begin
			foreach (tick_moves[k])
				expected_moves = {expected_moves, tick_moves[k]};
		end
	endtask

	task automatic set_limits(input logic [mjsr_pkg::SPD_W-1:0] spd,
			input logic [mjsr_pkg::SPD_W-1:0] acc,
			input logic on, input logic [mjsr_pkg::DZW_W-1:0] wid);
		in_ch.valid <= 1'b0;
		while (expected_moves.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= mjsr_pkg::CFG_MAX_SPEED;
		cfg_data <= spd;
		@(posedge clk);
		lim_speed = spd;
		cfg_idx <= mjsr_pkg::CFG_MAX_ACCEL;
		cfg_data <= acc;
		@(posedge clk);
		lim_accel = acc;
		cfg_idx <= mjsr_pkg::CFG_DZ_ON;
		cfg_data <= mjsr_pkg::CFG_DATA_W'(on);
		@(posedge clk);
		dz_on = on;
		cfg_idx <= mjsr_pkg::CFG_DZ_WIDTH;
		cfg_data <= mjsr_pkg::CFG_DATA_W'(wid);
		@(posedge clk);
		dz_width = wid;
		cfg_we <= 1'b0;
	endtask

	task automatic run_burst(input int count);
		stim_row_t r;
		logic signed [mjsr_pkg::ANG_W-1:0] base;
		for (int k = 0; k < count; k++) begin
			r.typed = 1'b0;
			r.typed_one = 1'b0;
			r.typed_move = NO_MOVE;
			r.joint = mjsr_pkg::IDX_W'($urandom_range(0, mjsr_pkg::JOINTS - 1));
			r.angle = $urandom;
			r.dt = mjsr_pkg::DT_W'($urandom_range(0, 65535));
			if ($urandom_range(0, 99) < 35) begin
				r.func = FUNC_TICK;
				if ($urandom_range(0, 7) == 0)
					r.dt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			end else begin
				r.func = FUNC_TARGET;
				base = ramp_pos[r.joint];
				case ($urandom_range(0, 3))
					0: ;
					1: r.angle = 32'(longint'(base) + longint'($urandom_range(0, 2 * dz_width + 16))
							- longint'(dz_width) - 8);
					2: r.angle = 32'(longint'(base) + ($urandom_range(0, 1) ? 1 : -1)
							* (longint'(dz_width) - longint'($urandom_range(0, 1))));
					default: r.angle = 32'(longint'($urandom_range(0, 1 << 22)) - (1 << 21));
				endcase
			end
			send_word(r);
		end
	endtask

	always @(posedge clk) begin : watch_moves
		move_word_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_moves.size() == 0) begin
				if (misses < 10)
					$display("unexpected word: joint %0d position %0d last %0b",
						out_ch.joint_out, out_ch.position, out_ch.last);
				misses++;
			end else begin
				want = expected_moves.pop_front();
				if (want.joint !== out_ch.joint_out || want.position !== out_ch.position
						|| want.last !== out_ch.last) begin
					if (misses < 10)
						$display({"word mismatch: expected joint %0d position %0d last %0b,",
							" got joint %0d position %0d last %0b"},
							want.joint, want.position, want.last,
							out_ch.joint_out, out_ch.position, out_ch.last);
					misses++;
				end
			end
		end
		out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("multi_joint_setpoint_ramp regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= mjsr_pkg::CFG_MAX_SPEED;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.func <= FUNC_TARGET;
		in_ch.joint_index <= '0;
		in_ch.target_angle <= '0;
		in_ch.elapsed <= '0;
		for (int i = 0; i < mjsr_pkg::JOINTS; i++) begin
			ramp_pos[i] = '0;
			ramp_goal[i] = '0;
			ramp_speed[i] = '0;
			ramp_known[i] = 1'b0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < $size(directed_rows); k++)
			send_word(directed_rows[k]);

		set_limits(23'd4194304, 23'd4194304, 1'b0, 21'd0);
		tx_idle_pct = 59;
		run_burst(RANDOM_WORDS);

		set_limits(23'd0, 23'd0, 1'b1, 21'd1048576);
		tx_idle_pct = 0;
		rx_stall_pct <= 59;
		run_burst(RANDOM_WORDS);

		set_limits(mjsr_pkg::SPD_W'($urandom_range(0, 4194304)),
			mjsr_pkg::SPD_W'($urandom_range(0, 4194304)),
			1'b1, mjsr_pkg::DZW_W'($urandom_range(0, 1048576)));
		tx_idle_pct = 30;
		rx_stall_pct <= 30;
		run_burst(RANDOM_WORDS);

		set_limits(mjsr_pkg::MAX_SPEED_RST, mjsr_pkg::MAX_ACCEL_RST,
			mjsr_pkg::DZ_ON_RST, mjsr_pkg::DZ_WIDTH_RST);
		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		run_burst(RANDOM_WORDS);

		in_ch.valid <= 1'b0;
		while (expected_moves.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (misses == 0)
			$display("multi_joint_setpoint_ramp regression: pass");
		else
			$display("multi_joint_setpoint_ramp regression: fail");
		$finish;
	end

endmodule

>>> files.f
src/mjsr_pkg.sv
src/mjsr_if.sv
src/mjsr_ctrl.sv
src/mjsr_dp.sv
src/multi_joint_setpoint_ramp.sv
sim/tb_top.sv
